FILE: sv/gnos_pkg.sv
// Shared types and constants for the gradient noise octave sum block.
// Used by the gradient table, the octave engine and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gnos_pkg;

    // Grid geometry and the gradient table that follows from it.
    localparam int GRID_CELLS  = 64;
    localparam int GRID_PITCH  = GRID_CELLS + 1;
    localparam int TABLE_DEPTH = GRID_PITCH * GRID_PITCH;
    localparam int TAB_AW      = $clog2(TABLE_DEPTH);
    localparam int CELL_W      = (GRID_CELLS > 2) ? $clog2(GRID_CELLS) : 1;
    localparam int MAX_OCTAVES = 8;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OCTAVE_COUNT   = 2'd0;
    localparam logic [1:0] CFG_PERSISTENCE    = 2'd1;
    localparam logic [1:0] CFG_BASE_AMPLITUDE = 2'd2;
    localparam logic [1:0] CFG_BASE_STEP      = 2'd3;

    // Request kinds.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [3:0]  octave_count;
        logic [15:0] persistence;
        logic [15:0] base_amplitude;
        logic [22:0] base_step;
    } t_cfg;

    typedef struct packed {
        logic               req_type;
        logic [12:0]        grad_index;
        logic signed [15:0] grad_x;
        logic signed [15:0] grad_y;
        logic [11:0]        pixel_col;
        logic [11:0]        pixel_row;
    } t_job;

    typedef struct packed {
        logic signed [31:0] noise_value;
        logic               range_error;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [TAB_AW-1:0] waddr;
        logic [31:0]       wdata;
        logic              re;
        logic [TAB_AW-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: sv/gnos_grad_mem.sv
// Gradient table: one write port and one registered read port.
// Depends on gnos_pkg for the table depth and address width.
`timescale 1ns / 1ps
`default_nettype none

module gnos_grad_mem
    import gnos_pkg::*;
(
    input  wire logic        i_clk,
    input  wire t_mem_req    i_req,
    output logic [31:0]      o_rdata
);

    logic [31:0] r_mem [TABLE_DEPTH];
    logic [31:0] r_rdata;

    // Entry holds x in the low half and y in the high half.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/gnos_engine.sv
// Octave engine: sequencer and datapath that read the gradient table per octave.
// Depends on gnos_pkg; drives the table port of gnos_grad_mem.
`timescale 1ns / 1ps
`default_nettype none

module gnos_engine
    import gnos_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_start,
    input  wire t_job     i_job,
    output logic          o_idle,
    output logic          o_done,
    input  wire logic     i_ack,
    output t_result       o_result,
    output t_mem_req      o_mem,
    input  wire logic [31:0] i_rdata
);

    typedef enum logic [2:0] {S_IDLE, S_OCT, S_EVAL, S_DONE} t_state;

    t_state                 r_state;
    logic [3:0]             r_oct;
    logic [3:0]             r_noct;
    logic [3:0]             r_step;
    logic [34:0]            r_px_base;
    logic [34:0]            r_py_base;
    logic [31:0]            r_amp;
    logic signed [33:0]     r_sum;
    logic                   r_err;
    logic [15:0]            r_fx;
    logic [15:0]            r_fy;
    logic [TAB_AW-1:0]      r_base;
    logic signed [34:0]     r_v [4];
    logic signed [34:0]     r_nx0;
    logic signed [34:0]     r_nx1;
    logic signed [34:0]     r_by;
    logic signed [53:0]     r_prod;
    t_result                r_res;

    // Linear blend a*(1-f) + b*f, rounded from Q.46 back to Q.30.
    function automatic logic signed [34:0] blend(input logic signed [34:0] a,
                                                 input logic signed [34:0] b,
                                                 input logic [15:0] f);
        logic signed [35:0] diff;
        logic signed [52:0] prod;
        logic signed [52:0] full;
        diff = 36'(b) - 36'(a);
        prod = diff * $signed({1'b0, f});
        full = (53'(a) <<< 16) + prod + 53'sd32768;
        return full[50:16];
    endfunction

    // Dot product of a stored gradient with the offset to corner k.
    function automatic logic signed [34:0] corner_dot(input logic [31:0] g,
                                                      input logic [1:0] k,
                                                      input logic [15:0] fx,
                                                      input logic [15:0] fy);
        logic signed [17:0] dx;
        logic signed [17:0] dy;
        logic signed [33:0] px;
        logic signed [33:0] py;
        dx = k[0] ? $signed({2'b11, fx}) : $signed({2'b00, fx});
        dy = k[1] ? $signed({2'b11, fy}) : $signed({2'b00, fy});
        px = dx * $signed(g[15:0]);
        py = dy * $signed(g[31:16]);
        return 35'(px) + 35'(py);
    endfunction

    // Octave coordinates and cell checks.
    logic [41:0]        w_px;
    logic [41:0]        w_py;
    logic [25:0]        w_cx;
    logic [25:0]        w_cy;
    logic               w_off_grid;
    logic [TAB_AW-1:0]  w_base;
    logic [31:0]        w_amp_next;
    logic [47:0]        w_amp_prod;
    logic [1:0]         w_rd_k;
    logic [1:0]         w_dot_k;
    logic signed [35:0] w_n_wide;
    logic signed [20:0] w_n;
    logic signed [54:0] w_contrib_wide;
    logic signed [29:0] w_contrib;
    logic [3:0]         w_noct;

    assign w_px       = 42'(r_px_base) << r_oct[2:0];
    assign w_py       = 42'(r_py_base) << r_oct[2:0];
    assign w_cx       = w_px[41:16];
    assign w_cy       = w_py[41:16];
    assign w_off_grid = (w_cx >= 26'(GRID_CELLS)) || (w_cy >= 26'(GRID_CELLS));
    assign w_base     = TAB_AW'(w_cx[CELL_W-1:0])
                      + TAB_AW'(w_cy[CELL_W-1:0]) * TAB_AW'(GRID_PITCH);
    assign w_amp_prod = 48'(r_amp) * 48'(i_cfg.persistence);
    assign w_amp_next = 32'((w_amp_prod + 48'd32768) >> 16);
    assign w_rd_k     = r_step[1:0];
    assign w_dot_k    = 2'(r_step - 4'd1);
    assign w_n_wide   = 36'(r_by) + 36'sd8192;
    assign w_n        = w_n_wide[34:14];
    assign w_contrib_wide = 55'(r_prod) + 55'sd8388608;
    assign w_contrib  = w_contrib_wide[53:24];
    assign w_noct     = (i_cfg.octave_count > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES)
                                                                : i_cfg.octave_count;

    // Table port: in-range writes come from an accepted write beat, reads from S_EVAL.
    always_comb begin
        o_mem.we    = i_start && (r_state == S_IDLE) && (i_job.req_type == REQ_WRITE)
                      && (32'(i_job.grad_index) < 32'(TABLE_DEPTH));
        o_mem.waddr = TAB_AW'(i_job.grad_index);
        o_mem.wdata = {i_job.grad_y, i_job.grad_x};
        o_mem.re    = (r_state == S_EVAL) && (r_step < 4'd4);
        o_mem.raddr = r_base + (w_rd_k[0] ? TAB_AW'(1) : TAB_AW'(0))
                             + (w_rd_k[1] ? TAB_AW'(GRID_PITCH) : TAB_AW'(0));
    end

    // Sequencer and datapath registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oct   <= '0;
            r_noct  <= '0;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_oct  <= '0;
                        if (i_job.req_type == REQ_WRITE) begin
                            r_noct  <= '0;
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_noct    <= w_noct;
                            r_px_base <= 35'(i_job.pixel_col) * 35'(i_cfg.base_step);
                            r_py_base <= 35'(i_job.pixel_row) * 35'(i_cfg.base_step);
                            r_amp     <= {i_cfg.base_amplitude, 16'd0};
                            r_sum     <= '0;
                            r_err     <= 1'b0;
                            r_state   <= S_OCT;
                        end
                    end
                end
                S_OCT: begin
                    if (r_oct == r_noct) begin
                        if (r_sum > 34'sd2147483647) begin
                            r_res.noise_value <= 32'sh7FFFFFFF;
                        end else if (r_sum < -34'sd2147483648) begin
                            r_res.noise_value <= 32'sh80000000;
                        end else begin
                            r_res.noise_value <= r_sum[31:0];
                        end
                        r_res.range_error <= r_err;
                        r_state <= S_DONE;
                    end else if (w_off_grid) begin
                        // Octave off the grid: flag it, add nothing.
                        r_err <= 1'b1;
                        r_amp <= w_amp_next;
                        r_oct <= r_oct + 4'd1;
                    end else begin
                        r_fx    <= w_px[15:0];
                        r_fy    <= w_py[15:0];
                        r_base  <= w_base;
                        r_step  <= '0;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_step <= r_step + 4'd1;
                    unique case (r_step)
                        4'd1, 4'd2, 4'd3, 4'd4: begin
                            r_v[w_dot_k] <= corner_dot(i_rdata, w_dot_k, r_fx, r_fy);
                        end
                        4'd5: r_nx0 <= blend(r_v[0], r_v[1], r_fx);
                        4'd6: r_nx1 <= blend(r_v[2], r_v[3], r_fx);
                        4'd7: r_by  <= blend(r_nx0, r_nx1, r_fy);
                        4'd8: r_prod <= w_n * $signed({1'b0, r_amp});
                        4'd9: begin
                            r_sum   <= r_sum + 34'(w_contrib);
                            r_amp   <= w_amp_next;
                            r_oct   <= r_oct + 4'd1;
                            r_state <= S_OCT;
                        end
                        default: ;
                    endcase
                end
                S_DONE: begin
                    if (i_ack) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle   = (r_state == S_IDLE);
    assign o_done   = (r_state == S_DONE);
    assign o_result = r_res;

    // Table writes happen only when a new beat is taken.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.we |-> (r_state == S_IDLE))
        else $error("gradient write outside idle");

    // Corner reads stay inside the table.
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem.re |-> (32'(o_mem.raddr) < 32'(TABLE_DEPTH)))
        else $error("corner read beyond table");

    // The octave counter never passes the octave limit while working.
    a_oct_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OCT || r_state == S_EVAL) |-> (r_oct <= r_noct))
        else $error("octave counter overrun");

    // A delivered result frees the engine.
    a_ack_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && i_ack) |=> o_idle)
        else $error("engine did not return to idle");

endmodule

`default_nettype wire

FILE: sv/gradient_noise_octave_sum.sv
// Top level of the gradient noise octave sum: stream ports, configuration
// registers and output register. Depends on gnos_pkg, gnos_grad_mem, gnos_engine.
//
// Each beat on the slave stream is either a gradient write (tuser 0) or a noise
// sample request (tuser 1), and each produces exactly one result beat. One item
// is in work at a time. For a sample, every octave on the grid reads the four
// corner gradients one at a time through the single read port of the gradient
// table, then runs the blends and the amplitude multiply through one multiplier
// stage each; an off-grid octave is flagged and adds nothing. The result waits in
// an output register, so the next beat can be taken while it is still held. The
// table has no reset and must be loaded before samples touch it; configuration
// must be written only while the block is idle; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module gradient_noise_octave_sum
    import gnos_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Slave stream.
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // tdata: grad_index[12:0], grad_x[28:13], grad_y[44:29],
    //        pixel_col[56:45], pixel_row[68:57], zero [71:69]
    input  wire logic [71:0] i_s_axis_tdata,
    // tuser: req_type[0]
    input  wire logic        i_s_axis_tuser,
    // Master stream.
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // tdata: noise_value[31:0]
    output logic [31:0]      o_m_axis_tdata,
    // tuser: range_error[0]
    output logic             o_m_axis_tuser,
    // Configuration write channel.
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [22:0] i_cfg_data
);

    t_cfg     r_cfg;
    t_job     w_job;
    t_result  w_result;
    t_mem_req w_mem;
    logic     w_idle;
    logic     w_done;
    logic     w_take;
    logic     w_start;
    logic [31:0] w_rdata;
    logic     r_ovalid;
    t_result  r_out;

    // Unpack the slave beat.
    assign w_job.req_type   = i_s_axis_tuser;
    assign w_job.grad_index = i_s_axis_tdata[12:0];
    assign w_job.grad_x     = i_s_axis_tdata[28:13];
    assign w_job.grad_y     = i_s_axis_tdata[44:29];
    assign w_job.pixel_col  = i_s_axis_tdata[56:45];
    assign w_job.pixel_row  = i_s_axis_tdata[68:57];

    assign o_s_axis_tready = w_idle;
    assign w_start         = i_s_axis_tvalid && w_idle;
    assign o_cfg_ready     = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.octave_count   <= 4'd1;
            r_cfg.persistence    <= 16'd32768;
            r_cfg.base_amplitude <= 16'd256;
            r_cfg.base_step      <= 23'd65536;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OCTAVE_COUNT:   r_cfg.octave_count   <= i_cfg_data[3:0];
                CFG_PERSISTENCE:    r_cfg.persistence    <= i_cfg_data[15:0];
                CFG_BASE_AMPLITUDE: r_cfg.base_amplitude <= i_cfg_data[15:0];
                CFG_BASE_STEP:      r_cfg.base_step      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gnos_grad_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (w_mem),
        .o_rdata (w_rdata)
    );

    gnos_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_start  (w_start),
        .i_job    (w_job),
        .o_idle   (w_idle),
        .o_done   (w_done),
        .i_ack    (w_take),
        .o_result (w_result),
        .o_mem    (w_mem),
        .i_rdata  (w_rdata)
    );

    // Output register: take a finished result when the slot is free or draining.
    assign w_take = w_done && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_take) begin
            r_ovalid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out.noise_value;
    assign o_m_axis_tuser  = r_out.range_error;

endmodule

`default_nettype wire
